### src/iies_pkg.sv
// Shared types and constants for the indexed insert/extract stack.
// No dependencies; imported by every module of the block.
package iies_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 6;
    localparam int WORD_W = 32;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic             load;
        logic             ins_en;
        logic             ext_en;
        logic             peek_en;
        logic [POS_W-1:0] pos;
    } ctrl_t;

endpackage

### src/iies_cell.sv
// One storage cell of the stack chain; holds the entry at position INDEX.
// Depends on iies_pkg (ctrl_t).
module iies_cell
    import iies_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  ctrl_t                 ctrl,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] above,
    input  logic [DATA_WIDTH-1:0] below,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic [DATA_WIDTH-1:0] tap_next;
    logic                  at_pos;
    logic                  past_pos;
    logic                  hit;

    assign at_pos   = (INDEX == 32'(ctrl.pos));
    assign past_pos = (INDEX > 32'(ctrl.pos));
    assign hit      = (ctrl.ext_en && at_pos) || (ctrl.peek_en && INDEX == 0);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins_en)
        begin
            if (at_pos)
                data_next = din;
            else if (past_pos)
                data_next = above;
        end
        else if (ctrl.ext_en && (at_pos || past_pos))
        begin
            data_next = below;
        end
        tap_next = hit ? data_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= data_next;
            tap_reg  <= tap_next;
        end
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

### src/indexed_insert_extract_stack.sv
// Indexed insert/extract stack: top level, command decode and result register.
// Cell and tap registers load on accept; the output register loads once it is free.
// A new word waits until the last result moves on (cell update, then tap reduction).
// Cells from the given position downward shift in the accept cycle.
// Reset (rst_n low, async) empties the stack and drops any word in flight.
module indexed_insert_extract_stack
    import iies_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int OUT_W     = ((ST_W + WORD_W + CNT_W + 7) / 8) * 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // command[1:0], position[7:2], data_in[39:8]
    input  logic [CMD_W+POS_W+WORD_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], data_out[33:2], entry_count[34+CNT_W-1:34], zero pad
    output logic [OUT_W-1:0]             m_tdata
);

    logic [CMD_W-1:0]      cmd;
    logic [POS_W-1:0]      pos;
    logic [WORD_W-1:0]     data_in;
    logic                  accept;
    logic                  advance;
    ctrl_t                 ctrl;
    logic [ST_W-1:0]       status;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  busy_reg;
    logic [ST_W-1:0]       st_reg;
    logic                  out_valid_reg;
    logic [ST_W-1:0]       out_status_reg;
    logic [WORD_W-1:0]     out_data_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic [DATA_WIDTH-1:0] din_w;
    logic [DATA_WIDTH-1:0] data_arr [DEPTH];
    logic [DATA_WIDTH-1:0] tap_arr  [DEPTH];
    logic [DATA_WIDTH-1:0] tap_or;

    assign cmd     = s_tdata[CMD_W-1:0];
    assign pos     = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign data_in = s_tdata[CMD_W+POS_W+WORD_W-1:CMD_W+POS_W];
    assign din_w   = DATA_WIDTH'(data_in);

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign advance  = busy_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        status       = ST_OK;
        count_next   = count_reg;
        ctrl.load    = accept;
        ctrl.ins_en  = 1'b0;
        ctrl.ext_en  = 1'b0;
        ctrl.peek_en = 1'b0;
        ctrl.pos     = pos;
        case (cmd)
            CMD_INSERT:
            begin
                if (32'(pos) > 32'(count_reg))
                    status = ST_RANGE;
                else if (32'(count_reg) >= DEPTH)
                    status = ST_FULL;
                else
                begin
                    ctrl.ins_en = accept;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            CMD_EXTRACT:
            begin
                if (count_reg == '0)
                    status = (pos == '0) ? ST_EMPTY : ST_RANGE;
                else if (32'(pos) >= 32'(count_reg))
                    status = ST_RANGE;
                else
                begin
                    ctrl.ext_en = accept;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            CMD_PEEK:
            begin
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                    ctrl.peek_en = accept;
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] above;
        logic [DATA_WIDTH-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_mid_a
            assign above = data_arr[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign below = '0;
        end
        else
        begin : g_mid_b
            assign below = data_arr[i+1];
        end

        iies_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .din   (din_w),
            .above (above),
            .below (below),
            .data  (data_arr[i]),
            .tap   (tap_arr[i])
        );
    end

    // at most one tap is nonzero
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
            tap_or = tap_or | tap_arr[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                busy_reg  <= 1'b1;
            end
            else if (advance)
            begin
                busy_reg <= 1'b0;
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            st_reg <= status;
        if (advance)
        begin
            out_status_reg <= st_reg;
            out_data_reg   <= WORD_W'(tap_or);
            out_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_count_reg, out_data_reg, out_status_reg});

endmodule

### src/iies_checker.sv
// Port-level checks for indexed_insert_extract_stack, attached by bind.
// Depends on iies_pkg (status codes, field widths).
module iies_checker
    import iies_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int OUT_W   = ((ST_W + WORD_W + CNT_W + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [ST_W-1:0]   st;
    logic [WORD_W-1:0] dout;
    logic [CNT_W-1:0]  cnt;

    assign st   = m_tdata[ST_W-1:0];
    assign dout = m_tdata[ST_W+WORD_W-1:ST_W];
    assign cnt  = m_tdata[ST_W+WORD_W+CNT_W-1:ST_W+WORD_W];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(cnt) <= DEPTH)
        else $error("entry count above depth");

    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st == ST_FULL) |-> 32'(cnt) == DEPTH)
        else $error("full status with stack not full");

    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st == ST_EMPTY) |-> cnt == '0)
        else $error("empty status with entries held");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st != ST_OK) |-> dout == '0)
        else $error("nonzero data on failed command");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word dropped or changed while stalled");

endmodule

bind indexed_insert_extract_stack iies_checker #(
    .DEPTH (DEPTH)
) u_iies_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/tb_indexed_insert_extract_stack.sv
// Testbench for indexed_insert_extract_stack: directed and random command streams,
// checked against a queue-based stack model. Depends on iies_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_indexed_insert_extract_stack;
    import iies_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IN_W     = CMD_W + POS_W + WORD_W;
    localparam int OUT_W    = ((ST_W + WORD_W + CNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } stack_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;  // command[1:0], position[7:2], data_in[39:8]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;       // status[1:0], data_out[33:2], entry_count[40:34], pad

    logic [WORD_W-1:0] model_stack[$];   // index 0 is the top
    stack_result_t     pending_results[$];
    int                error_count = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_request = 0;
    int                hold_left = 0;

    indexed_insert_extract_stack dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_indexed_insert_extract_stack: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic stack_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                    logic [POS_W-1:0] pos,
                                                    logic [WORD_W-1:0] din);
        stack_result_t res;
        int size;
        size = model_stack.size();
        res.status = ST_OK;
        res.data = '0;
        case (cmd)
            CMD_INSERT:
            begin
                if (pos > size)
                    res.status = ST_RANGE;
                else if (size >= DEPTH)
                    res.status = ST_FULL;
                else
                    model_stack.insert(pos, din);
            end
            CMD_EXTRACT:
            begin
                if (size == 0)
                    res.status = (pos == 0) ? ST_EMPTY : ST_RANGE;
                else if (pos >= size)
                    res.status = ST_RANGE;
                else
                begin
                    res.data = model_stack[pos];
                    model_stack.delete(pos);
                end
            end
            CMD_PEEK:
            begin
                if (size == 0)
                    res.status = ST_EMPTY;
                else
                    res.data = model_stack[0];
            end
            default:
            begin
                model_stack.delete();
            end
        endcase
        res.count = CNT_W'(model_stack.size());
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected word", WORD_W'(m_tdata[1:0]), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", WORD_W'(m_tdata[1:0]), WORD_W'(want.status));
                if (m_tdata[33:2] !== want.data)
                    report_mismatch("data_out", m_tdata[33:2], want.data);
                if (m_tdata[34 +: CNT_W] !== want.count)
                    report_mismatch("entry_count", WORD_W'(m_tdata[34 +: CNT_W]),
                                    WORD_W'(want.count));
            end
        end
    end

    // Called just after a rising edge; leaves s_tvalid high after the accept.
    task automatic send_word(logic [CMD_W-1:0] cmd, int pos,
                             logic [WORD_W-1:0] din);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {din, POS_W'(pos), cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_command(cmd, POS_W'(pos), din));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Mostly legal positions; some noise over the whole field.
    task automatic send_random(int insert_pct);
        int r;
        int size;
        int pos;
        size = model_stack.size();
        r = $urandom_range(99);
        if (r < insert_pct)
        begin
            pos = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(size);
            send_word(CMD_INSERT, pos, random_word());
        end
        else if (r < 88)
        begin
            if ($urandom_range(9) == 0 || size == 0)
                pos = $urandom_range(63);
            else
                pos = $urandom_range(size - 1);
            send_word(CMD_EXTRACT, pos, random_word());
        end
        else if (r < 98)
        begin
            send_word(CMD_PEEK, $urandom_range(63), random_word());
        end
        else
        begin
            send_word(CMD_CLEAR, $urandom_range(63), random_word());
        end
    endtask

    task automatic test_directed();
        send_word(CMD_PEEK, 0, '0);
        send_word(CMD_EXTRACT, 0, '0);
        send_word(CMD_EXTRACT, 63, '1);
        send_word(CMD_INSERT, 1, 32'h1234_5678);
        send_word(CMD_INSERT, 0, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 0, 32'h0000_0000);
        send_word(CMD_INSERT, 2, 32'hA5A5_A5A5);
        send_word(CMD_INSERT, 1, 32'h5A5A_5A5A);
        send_word(CMD_PEEK, 7, '1);
        send_word(CMD_INSERT, 63, 32'hDEAD_BEEF);
        send_word(CMD_EXTRACT, 4, '0);
        send_word(CMD_EXTRACT, 1, '0);
        send_word(CMD_EXTRACT, 2, '0);
        send_word(CMD_EXTRACT, 0, '0);
        send_word(CMD_CLEAR, 0, '0);
        send_word(CMD_PEEK, 0, '0);
        send_word(CMD_CLEAR, 63, '1);
        send_word(CMD_INSERT, 0, 32'h8000_0001);
        send_word(CMD_EXTRACT, 0, '0);
        wait_drain();
    endtask

    task automatic test_random_mix(int items, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items)
            send_random(55);
        wait_drain();
    endtask

    // Fill to full, bounce off the limit, drain by extracts and peeks, insert two entries and clear.
    task automatic test_fill_and_drain();
        send_idle_pct = 9;
        recv_stall_pct = 9;
        while (model_stack.size() < DEPTH)
            send_word(CMD_INSERT, $urandom_range(model_stack.size()), random_word());
        repeat (4)
            send_word(CMD_INSERT, $urandom_range(63), random_word());
        send_word(CMD_PEEK, 0, '0);
        send_word(CMD_EXTRACT, 63, '0);
        send_word(CMD_INSERT, 63, random_word());
        send_word(CMD_EXTRACT, 63, '0);
        while (model_stack.size() > 0)
        begin
            if ($urandom_range(7) == 0)
                send_word(CMD_PEEK, 0, '0);
            else
                send_word(CMD_EXTRACT, $urandom_range(model_stack.size() - 1), '0);
        end
        send_word(CMD_INSERT, 0, random_word());
        send_word(CMD_INSERT, 1, random_word());
        send_word(CMD_CLEAR, 0, '0);
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 300;
        repeat (40)
            send_random(70);
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(110, 0, 0);
        test_random_mix(110, 75, 0);
        test_random_mix(110, 0, 75);
        test_random_mix(110, 9, 9);
        test_fill_and_drain();
        test_output_backpressure();
        test_random_mix(60, 0, 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_indexed_insert_extract_stack: done, clean");
        else
            $display("tb_indexed_insert_extract_stack: done, errors");
        $finish;
    end

endmodule

### indexed_insert_extract_stack.f
src/iies_pkg.sv
src/iies_cell.sv
src/indexed_insert_extract_stack.sv
src/iies_checker.sv
tb/sv/tb_indexed_insert_extract_stack.sv
